@@ rtl/iena_pkg.sv @@
// Shared constants for the integer expression node ALU: field widths, operation and error codes.
package iena_pkg;

	// Widths of the transaction fields.
	localparam int FIELD_W = 64;
	localparam int KIND_W  = 3;
	localparam int ERR_W   = 2;

	// Default operand width used inside the datapath.
	localparam int DATA_WIDTH_DEF = 64;

	// Operation codes.
	localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REM = 3'd4;
	localparam logic [KIND_W-1:0] KIND_POW = 3'd5;

	// Error codes.
	localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
	localparam logic [ERR_W-1:0] ERR_DIV_ZERO = 2'd1;
	localparam logic [ERR_W-1:0] ERR_ZERO_POW = 2'd2;
	localparam logic [ERR_W-1:0] ERR_NEG_EXP  = 2'd3;

endpackage

@@ rtl/integer_expression_node_alu_core.sv @@
// Integer expression node ALU: add and subtract, and iterative multiply, divide, remainder and power.
//
// Usage: one input channel (in_valid/in_stall with kind, left_value, right_value) and one
// output channel (out_valid/out_stall with value, error). A transaction is accepted at a
// rising edge with valid high and stall low. Each input transaction yields exactly one
// output transaction. Only the low DATA_WIDTH bits of each operand are used, taken as two's
// complement, and value is sign-extended back to 64 bits; value is zero when error is set.
// How each operation is worked out (W = DATA_WIDTH):
//   add, subtract, unused codes and all error cases: result set at acceptance.
//   multiply: one pass of the shared multiplier over 16-bit digits.
//   divide and remainder: W restoring steps, one per cycle, then a sign fix.
//   power: one shared multiplier pass for each squaring and each accumulate, ending early
//   once the exponent runs out.
// One item is in work at a time; in_stall is high from acceptance until the result moves
// into the output register. The output register lets the next item be accepted while a
// result still waits. While out_stall is high, value and error hold and a finished result
// waits in its final state. Reset clears the sequencer and out_valid; no clearing pass.
module integer_expression_node_alu_core #(
	parameter int DATA_WIDTH = iena_pkg::DATA_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic        [iena_pkg::KIND_W-1:0]      kind,
	input  logic signed [iena_pkg::FIELD_W-1:0]     left_value,
	input  logic signed [iena_pkg::FIELD_W-1:0]     right_value,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [iena_pkg::FIELD_W-1:0]     value,
	output logic        [iena_pkg::ERR_W-1:0]       error
);

	localparam int W      = DATA_WIDTH;
	localparam int CHUNK  = (W < 16) ? W : 16;
	localparam int NCHUNK = (W + CHUNK - 1) / CHUNK;
	localparam int CW     = $clog2(W);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_DSGN = 3'd3;
	localparam logic [2:0] ST_POW  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	// Destinations of a multiplier pass.
	localparam logic [1:0] TGT_RES  = 2'd0;
	localparam logic [1:0] TGT_ACC  = 2'd1;
	localparam logic [1:0] TGT_BASE = 2'd2;

	logic [2:0]                  state_q;
	logic                        out_valid_q;
	logic [iena_pkg::KIND_W-1:0] kind_q;
	logic                        a_neg_q;
	logic                        b_neg_q;
	logic [W-1:0]                res_q;
	logic [iena_pkg::ERR_W-1:0]  err_q;
	logic [CW-1:0]               cnt_q;
	logic [W-1:0]                mul_a_q;
	logic [W-1:0]                mul_b_q;
	logic [W-1:0]                mul_acc_q;
	logic [1:0]                  mul_tgt_q;
	logic [W-1:0]                rem_q;
	logic [W-1:0]                quo_q;
	logic [W-1:0]                dvs_q;
	logic [W-1:0]                base_q;
	logic [W-1:0]                exp_q;
	logic [W-1:0]                pacc_q;
	logic signed [iena_pkg::FIELD_W-1:0] value_q;
	logic [iena_pkg::ERR_W-1:0]  error_q;

	logic                        in_acc;
	logic                        out_free;
	logic [W-1:0]                a_w;
	logic [W-1:0]                b_w;
	logic [W-1:0]                a_mag;
	logic [W-1:0]                b_mag;
	logic [W+CHUNK-1:0]          mul_prod;
	logic [W-1:0]                mul_sum;
	logic                        mul_last;
	logic [W:0]                  div_in;
	logic [W:0]                  div_trial;
	logic [W-1:0]                res_sext_src;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign error     = error_q;

	// Operand slices and magnitudes.
	assign a_w   = left_value[W-1:0];
	assign b_w   = right_value[W-1:0];
	assign a_mag = a_w[W-1] ? (W'(0) - a_w) : a_w;
	assign b_mag = b_w[W-1] ? (W'(0) - b_w) : b_w;

	// Shared multiplier: one digit of the multiplier operand per cycle (16 bits, or W if narrower).
	always_comb begin
		mul_prod = {{CHUNK{1'b0}}, mul_a_q} * {{W{1'b0}}, mul_b_q[CHUNK-1:0]};
		mul_sum  = mul_acc_q + mul_prod[W-1:0];
		mul_last = (cnt_q == CW'(NCHUNK - 1));
	end

	// One restoring division step.
	always_comb begin
		div_in    = {rem_q, quo_q[W-1]};
		div_trial = div_in - {1'b0, dvs_q};
	end

	assign res_sext_src = (err_q == iena_pkg::ERR_NONE) ? res_q : '0;

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (kind)
							iena_pkg::KIND_MUL: state_q <= ST_MUL;
							iena_pkg::KIND_DIV,
							iena_pkg::KIND_REM: begin
								state_q <= (b_w == '0) ? ST_FIN : ST_DIV;
							end
							iena_pkg::KIND_POW: begin
								if ((a_w == '0 && b_w == '0) || b_w[W-1]) begin
									state_q <= ST_FIN;
								end else begin
									state_q <= ST_POW;
								end
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_MUL: begin
					if (mul_last) begin
						state_q <= (mul_tgt_q == TGT_RES) ? ST_FIN : ST_POW;
					end
				end
				ST_DIV: begin
					if (cnt_q == CW'(W - 1)) begin
						state_q <= ST_DSGN;
					end
				end
				ST_DSGN: state_q <= ST_FIN;
				ST_POW: begin
					state_q <= (exp_q == '0) ? ST_FIN : ST_MUL;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					kind_q    <= kind;
					a_neg_q   <= a_w[W-1];
					b_neg_q   <= b_w[W-1];
					err_q     <= iena_pkg::ERR_NONE;
					res_q     <= '0;
					cnt_q     <= '0;
					mul_a_q   <= a_w;
					mul_b_q   <= b_w;
					mul_acc_q <= '0;
					mul_tgt_q <= TGT_RES;
					rem_q     <= '0;
					quo_q     <= a_mag;
					dvs_q     <= b_mag;
					base_q    <= a_w;
					exp_q     <= b_w;
					pacc_q    <= W'(1);
					case (kind)
						iena_pkg::KIND_ADD: res_q <= a_w + b_w;
						iena_pkg::KIND_SUB: res_q <= a_w - b_w;
						iena_pkg::KIND_DIV,
						iena_pkg::KIND_REM: begin
							if (b_w == '0) begin
								err_q <= iena_pkg::ERR_DIV_ZERO;
							end
						end
						iena_pkg::KIND_POW: begin
							if (a_w == '0 && b_w == '0) begin
								err_q <= iena_pkg::ERR_ZERO_POW;
							end else if (b_w[W-1]) begin
								err_q <= iena_pkg::ERR_NEG_EXP;
							end
						end
						default: res_q <= '0;
					endcase
				end
			end
			ST_MUL: begin
				mul_acc_q <= mul_sum;
				mul_a_q   <= mul_a_q << CHUNK;
				mul_b_q   <= mul_b_q >> CHUNK;
				cnt_q     <= cnt_q + CW'(1);
				if (mul_last) begin
					cnt_q <= '0;
					case (mul_tgt_q)
						TGT_ACC:  pacc_q <= mul_sum;
						TGT_BASE: base_q <= mul_sum;
						default:  res_q  <= mul_sum;
					endcase
				end
			end
			ST_DIV: begin
				cnt_q <= cnt_q + CW'(1);
				if (!div_trial[W]) begin
					rem_q <= div_trial[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= div_in[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
			end
			ST_DSGN: begin
				// Quotient truncates toward zero; remainder follows the dividend's sign.
				if (kind_q == iena_pkg::KIND_DIV) begin
					res_q <= (a_neg_q != b_neg_q) ? (W'(0) - quo_q) : quo_q;
				end else begin
					res_q <= a_neg_q ? (W'(0) - rem_q) : rem_q;
				end
			end
			ST_POW: begin
				// Finish once the exponent is spent; else either fold the base into the product or square the base.
				mul_acc_q <= '0;
				cnt_q     <= '0;
				if (exp_q == '0) begin
					res_q <= pacc_q;
				end else if (exp_q[0]) begin
					mul_a_q   <= pacc_q;
					mul_b_q   <= base_q;
					mul_tgt_q <= TGT_ACC;
					exp_q     <= {exp_q[W-1:1], 1'b0};
				end else begin
					mul_a_q   <= base_q;
					mul_b_q   <= base_q;
					mul_tgt_q <= TGT_BASE;
					exp_q     <= exp_q >> 1;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					value_q <= iena_pkg::FIELD_W'(signed'(res_sext_src));
					error_q <= err_q;
				end
			end
			default: cnt_q <= '0;
		endcase
	end

`ifndef SYNTHESIS
	// A flagged error always comes with a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error != iena_pkg::ERR_NONE) |-> (value == '0))
		else $error("error result carries a nonzero value");

	// The block is busy in the cycle after it takes a transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("block not busy after accepting a transaction");

	// A new result appears only out of the final state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_FIN))
		else $error("result presented outside the final state");
`endif

endmodule
